// File: sv/sitp_pkg.sv
// ----------------------------------------------------------------------------
// sitp_pkg
// Shared types and constants of the suffixed integer text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sitp_pkg;

  // configuration register indexes
  localparam logic CfgScaleBase    = 1'b0;
  localparam logic CfgUnsignedMode = 1'b1;

  localparam int unsigned ValueW     = 64;
  localparam int unsigned ScaleBaseW = 16;
  localparam int unsigned ExpW       = 2;

  localparam logic [ScaleBaseW-1:0] ScaleBaseReset    = 16'd1024;
  localparam logic                  UnsignedModeReset = 1'b0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic byte_step;   // parse one accepted word
    logic finish;      // convert the parse state, load the scale count, clear
    logic scale_step;  // one multiply by the scale base
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic scale_done;  // no multiply left
  } sts_t;

endpackage

`default_nettype wire

// File: sv/suffixed_integer_text_parser_unit.sv
// ----------------------------------------------------------------------------
// suffixed_integer_text_parser_unit
// Parses number text, one character per word, into a scaled 64-bit integer.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry text_byte_i and last_byte_i.
// A word is taken on a rising edge with valid high and stall low. Words that
// do not close a string are taken one per cycle. The word with last_byte_i
// set closes the string; the block then converts the parse state,
// multiplies by the scale base once per suffix step (zero to three times,
// none for hex, one 64 x 16 multiplier) and checks the count. The result
// then appears on value_o with out_valid_o. The input stalls during that
// sequence, and a closing word also stalls while an earlier result still
// waits in the output register.
// Output channel: out_valid_o / out_stall_i; value_o holds while stalled.
// Configuration: cfg_valid_i / cfg_ready_o (always ready), cfg_index_i
// selects scale base (0) or unsigned mode (1), cfg_data_i is the value.
// Write it only while the block is idle.
// Reset clears parse state and restores scale base 1024, signed mode.
// ----------------------------------------------------------------------------
`default_nettype none

module suffixed_integer_text_parser_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      text_byte_i,
  input  wire logic                            last_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [sitp_pkg::ValueW-1:0]          value_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic                            cfg_index_i,
  input  wire logic [sitp_pkg::ScaleBaseW-1:0] cfg_data_i
);

  sitp_pkg::cmd_t cmd;
  sitp_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sitp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sitp_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .text_byte_i (text_byte_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_o     (value_o)
  );

endmodule

`default_nettype wire

// File: sv/sitp_ctrl.sv
// ----------------------------------------------------------------------------
// sitp_ctrl
// Controller: input and output handshakes and the finish / scale sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module sitp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          last_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output sitp_pkg::cmd_t     cmd_o,
  input  wire sitp_pkg::sts_t sts_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StFin   = 2'd1;
  localparam logic [1:0] StScale = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept;

  assign in_stall_o = (state_q != StIdle) || (last_byte_i && out_valid_q);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          cmd_o.byte_step = 1'b1;
          if (last_byte_i) begin
            state_d = StFin;
          end
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d      = StScale;
      end
      StScale: begin
        if (sts_i.scale_done) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end else begin
          cmd_o.scale_step = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a finished string always goes on to the scale sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFin |=> state_q == StScale)
    else $error("finish not followed by scaling");

  // a new result only appears at the end of the scale sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StScale)
    else $error("result raised outside scaling");

  // the closing word of a string is never taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && last_byte_i |-> !out_valid_q)
    else $error("string closed over a pending result");

  // the datapath never multiplies and converts in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.finish && (cmd_o.scale_step || cmd_o.byte_step)))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: sv/sitp_dpath.sv
// ----------------------------------------------------------------------------
// sitp_dpath
// Datapath: character scan, accumulator, conversion and suffix scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module sitp_dpath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire sitp_pkg::cmd_t                      cmd_i,
  output sitp_pkg::sts_t                           sts_o,
  input  wire logic [7:0]                          text_byte_i,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_index_i,
  input  wire logic [sitp_pkg::ScaleBaseW-1:0]     cfg_data_i,
  output logic [sitp_pkg::ValueW-1:0]              value_o
);

  localparam logic [2:0] NpWs     = 3'd0;
  localparam logic [2:0] NpSign   = 3'd1;
  localparam logic [2:0] NpZero   = 3'd2;
  localparam logic [2:0] NpHexPfx = 3'd3;
  localparam logic [2:0] NpDigits = 3'd4;
  localparam logic [2:0] NpDone   = 3'd5;

  localparam logic [1:0] RadixDec = 2'd0;
  localparam logic [1:0] RadixOct = 2'd1;
  localparam logic [1:0] RadixHex = 2'd2;

  localparam logic [1:0] SpWs     = 2'd0;
  localparam logic [1:0] SpSigns  = 2'd1;
  localparam logic [1:0] SpDigits = 2'd2;
  localparam logic [1:0] SpDone   = 2'd3;

  localparam logic [4:0] DigitNone = 5'd16;

  localparam int unsigned VW = sitp_pkg::ValueW;

  // configuration registers
  logic [sitp_pkg::ScaleBaseW-1:0] scale_base_q;
  logic                            unsigned_mode_q;

  // parse state
  logic [2:0]    np_q, np_d;
  logic [VW-1:0] acc_q, acc_d;
  logic          neg_q, neg_d;
  logic [1:0]    radix_q, radix_d;
  logic          ovf_q, ovf_d;
  logic [1:0]    sp_q, sp_d;
  logic [sitp_pkg::ExpW-1:0] exp_q, exp_d;
  logic          ended_q, ended_d;

  // result and scale count
  logic [VW-1:0] out_q;
  logic [sitp_pkg::ExpW-1:0] cnt_q;

  logic [7:0]    c;
  logic          c_space;
  logic          c_dec;
  logic          c_sign_sfx;
  logic [4:0]    dval;
  logic [4:0]    dlim;
  logic          add_en;
  logic [1:0]    add_radix;
  logic          first_digit;
  logic [VW+3:0] add_prod;
  logic [VW+3:0] add_sum;
  logic [VW-1:0] conv_value;
  logic [VW-1:0] scale_prod;

  assign c       = text_byte_i;
  assign c_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign c_dec   = (c >= "0") && (c <= "9");
  assign c_sign_sfx = (c == "+") || (c == "-" && !unsigned_mode_q);

  always_comb begin
    if (c_dec) begin
      dval = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      dval = 5'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      dval = 5'(c - "A" + 8'd10);
    end else begin
      dval = DigitNone;
    end
  end

  assign dlim = (radix_q == RadixHex) ? 5'd16 : (radix_q == RadixOct) ? 5'd8 : 5'd10;

  // accumulator times radix plus digit, four guard bits catch overflow
  always_comb begin
    unique case (add_radix)
      RadixHex: add_prod = {acc_q, 4'b0};
      RadixOct: add_prod = {1'b0, acc_q, 3'b0};
      default:  add_prod = {3'b0, acc_q, 1'b0} + {1'b0, acc_q, 3'b0};
    endcase
    add_sum = add_prod + {{(VW-1){1'b0}}, dval};
  end

  always_comb begin
    np_d        = np_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    radix_d     = radix_q;
    ovf_d       = ovf_q;
    sp_d        = sp_q;
    exp_d       = exp_q;
    ended_d     = ended_q;
    add_en      = 1'b0;
    add_radix   = RadixDec;
    first_digit = 1'b0;

    if (!ended_q) begin
      if (c == 8'd0) begin
        ended_d = 1'b1;
      end else begin
        // number scan
        unique case (np_q)
          NpWs: begin
            if (c_space) begin
              np_d = np_q;
            end else if (c == "+" || c == "-") begin
              neg_d = (c == "-");
              np_d  = NpSign;
            end else begin
              first_digit = 1'b1;
            end
          end
          NpSign: begin
            first_digit = 1'b1;
          end
          NpZero: begin
            if (c == "x" || c == "X") begin
              radix_d = RadixHex;
              np_d    = NpHexPfx;
            end else if (dval < 5'd8) begin
              add_en    = 1'b1;
              add_radix = RadixOct;
              np_d      = NpDigits;
            end else begin
              np_d = NpDone;
            end
          end
          NpHexPfx: begin
            if (!dval[4]) begin
              add_en    = 1'b1;
              add_radix = RadixHex;
              np_d      = NpDigits;
            end else begin
              np_d = NpDone;
            end
          end
          NpDigits: begin
            if (dval < dlim) begin
              add_en    = 1'b1;
              add_radix = radix_q;
            end else begin
              np_d = NpDone;
            end
          end
          default: begin
            np_d = NpDone;
          end
        endcase

        if (first_digit) begin
          if (c == "0") begin
            radix_d = RadixOct;
            np_d    = NpZero;
          end else if (c_dec) begin
            radix_d   = RadixDec;
            add_en    = 1'b1;
            add_radix = RadixDec;
            np_d      = NpDigits;
          end else begin
            np_d = NpDone;
          end
        end

        if (add_en && !ovf_q) begin
          if (add_sum[VW+3:VW] != 4'd0) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = add_sum[VW-1:0];
          end
        end

        // suffix scan
        priority if (sp_q == SpDone) begin
          sp_d = sp_q;
        end else if (sp_q == SpWs && c_space) begin
          sp_d = sp_q;
        end else if (sp_q != SpDigits && c_sign_sfx) begin
          sp_d = SpSigns;
        end else if (c_dec) begin
          sp_d = SpDigits;
        end else begin
          if (c == "k" || c == "K") begin
            exp_d = 2'd1;
          end else if (c == "m" || c == "M") begin
            exp_d = 2'd2;
          end else if (c == "g" || c == "G" || c == "b" || c == "B") begin
            exp_d = 2'd3;
          end
          sp_d = SpDone;
        end
      end
    end
  end

  // conversion of the magnitude by sign and mode, saturating except for negative values in unsigned mode, which wrap
  always_comb begin
    if (unsigned_mode_q) begin
      if (ovf_q) begin
        conv_value = '1;
      end else if (neg_q) begin
        conv_value = '0 - acc_q;
      end else begin
        conv_value = acc_q;
      end
    end else if (neg_q) begin
      if (ovf_q || (acc_q[VW-1] && acc_q[VW-2:0] != '0)) begin
        conv_value = {1'b1, {(VW-1){1'b0}}};
      end else begin
        conv_value = '0 - acc_q;
      end
    end else begin
      if (ovf_q || acc_q[VW-1]) begin
        conv_value = {1'b0, {(VW-1){1'b1}}};
      end else begin
        conv_value = acc_q;
      end
    end
  end

  // 64 x 16 multiply, wraps modulo 2^64
  assign scale_prod = out_q * {{(VW-sitp_pkg::ScaleBaseW){1'b0}}, scale_base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_base_q    <= sitp_pkg::ScaleBaseReset;
      unsigned_mode_q <= sitp_pkg::UnsignedModeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sitp_pkg::CfgScaleBase:    scale_base_q    <= cfg_data_i;
        sitp_pkg::CfgUnsignedMode: unsigned_mode_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q    <= NpWs;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      radix_q <= RadixDec;
      ovf_q   <= 1'b0;
      sp_q    <= SpWs;
      exp_q   <= '0;
      ended_q <= 1'b0;
      cnt_q   <= '0;
    end else if (cmd_i.finish) begin
      np_q    <= NpWs;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      radix_q <= RadixDec;
      ovf_q   <= 1'b0;
      sp_q    <= SpWs;
      exp_q   <= '0;
      ended_q <= 1'b0;
      cnt_q   <= (radix_q == RadixHex) ? '0 : exp_q;
    end else if (cmd_i.byte_step) begin
      np_q    <= np_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      radix_q <= radix_d;
      ovf_q   <= ovf_d;
      sp_q    <= sp_d;
      exp_q   <= exp_d;
      ended_q <= ended_d;
    end else if (cmd_i.scale_step) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= conv_value;
    end else if (cmd_i.scale_step) begin
      out_q <= scale_prod;
    end
  end

  assign sts_o.scale_done = (cnt_q == '0);
  assign value_o          = out_q;

endmodule

`default_nettype wire
